### sv/arp_pkg.sv
package arp_pkg;

	localparam int MAP_ENTRIES_DEF  = 16;
	localparam int ASK_ENTRIES_DEF  = 16;
	localparam int PARK_ENTRIES_DEF = 16;

	localparam logic [15:0] LIFETIME_RST = 16'd30000;
	localparam logic [15:0] HOLDOFF_RST  = 16'd5000;
	localparam logic [47:0] BCAST_MAC    = 48'hFFFF_FFFF_FFFF;

	localparam logic [1:0] KIND_SEND = 2'd0;
	localparam logic [1:0] KIND_RECV = 2'd1;
	localparam logic [1:0] KIND_TICK = 2'd2;
	localparam logic [1:0] KIND_RSVD = 2'd3;

	localparam logic [1:0] CLS_IPV4  = 2'd0;
	localparam logic [1:0] CLS_ARP   = 2'd1;
	localparam logic [1:0] CLS_OTHER = 2'd2;
	localparam logic [1:0] CLS_RSVD  = 2'd3;

	localparam logic [1:0] RES_FRAME   = 2'd0;
	localparam logic [1:0] RES_REQUEST = 2'd1;
	localparam logic [1:0] RES_REPLY   = 2'd2;
	localparam logic [1:0] RES_DELIVER = 2'd3;

	localparam logic [1:0] CFG_OWN_MAC  = 2'd0;
	localparam logic [1:0] CFG_OWN_IP   = 2'd1;
	localparam logic [1:0] CFG_LIFETIME = 2'd2;
	localparam logic [1:0] CFG_HOLDOFF  = 2'd3;

	typedef enum logic [2:0] {
		OP_SEND,
		OP_LEARN,
		OP_DELIVER,
		OP_TICK,
		OP_NONE
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] ip;
		logic [47:0] mac;
		logic [7:0]  tag;
		logic        reply;
		logic [15:0] elapsed;
	} cmd_t;

endpackage

### sv/arp_resolution_engine.sv
// ARP resolution engine.
// Input channel: one transaction per event (send, received frame, tick),
// accepted on in_valid high and in_stall low. Output channel: result
// transactions on out_valid, held while out_stall is high; last marks the
// final result of one input event. Events that cause no result emit nothing.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; write
// only while idle. cfg_ready is always high.
// A front stage classifies each event into a two-entry command queue; the
// back sequencer walks the cache and request tables one entry per cycle.
// The sequencer takes a new command only once it is back in idle. A send or
// received ARP frame walks both tables and then decides; a received ARP
// frame then releases each matching datagram from the park queue. A tick
// walks the tables to age them; an IPv4 delivery skips the walk. Reset
// clears the cache, request table, park queue and registers to their
// defaults at once. A stalled output holds the sequencer when it must emit.
module arp_resolution_engine #(
	parameter int MAP_ENTRIES  = arp_pkg::MAP_ENTRIES_DEF,
	parameter int ASK_ENTRIES  = arp_pkg::ASK_ENTRIES_DEF,
	parameter int PARK_ENTRIES = arp_pkg::PARK_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [31:0] hop_ip,
	input  logic [7:0]  datagram_tag,
	input  logic [1:0]  frame_class,
	input  logic        parse_ok,
	input  logic [47:0] frame_dst_mac,
	input  logic        arp_is_request,
	input  logic [31:0] sender_ip,
	input  logic [47:0] sender_mac,
	input  logic [31:0] target_ip,
	input  logic [15:0] elapsed_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  result_kind,
	output logic [47:0] dst_mac,
	output logic [31:0] addr_ip,
	output logic [7:0]  out_tag,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_data
);

	logic [47:0]   own_mac_q;
	logic [31:0]   own_ip_q;
	logic [15:0]   lifetime_q;
	logic [15:0]   holdoff_q;
	logic          cmd_valid;
	logic          cmd_take;
	arp_pkg::cmd_t cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_mac_q  <= '0;
			own_ip_q   <= '0;
			lifetime_q <= arp_pkg::LIFETIME_RST;
			holdoff_q  <= arp_pkg::HOLDOFF_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				arp_pkg::CFG_OWN_MAC:  own_mac_q  <= cfg_data;
				arp_pkg::CFG_OWN_IP:   own_ip_q   <= cfg_data[31:0];
				arp_pkg::CFG_LIFETIME: lifetime_q <= cfg_data[15:0];
				arp_pkg::CFG_HOLDOFF:  holdoff_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	arp_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.kind           (kind),
		.hop_ip         (hop_ip),
		.datagram_tag   (datagram_tag),
		.frame_class    (frame_class),
		.parse_ok       (parse_ok),
		.frame_dst_mac  (frame_dst_mac),
		.arp_is_request (arp_is_request),
		.sender_ip      (sender_ip),
		.sender_mac     (sender_mac),
		.target_ip      (target_ip),
		.elapsed_ms     (elapsed_ms),
		.own_mac_q      (own_mac_q),
		.own_ip_q       (own_ip_q),
		.cmd_valid      (cmd_valid),
		.cmd_take       (cmd_take),
		.cmd            (cmd)
	);

	arp_back #(
		.MAP_ENTRIES  (MAP_ENTRIES),
		.ASK_ENTRIES  (ASK_ENTRIES),
		.PARK_ENTRIES (PARK_ENTRIES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_take    (cmd_take),
		.cmd         (cmd),
		.lifetime_q  (lifetime_q),
		.holdoff_q   (holdoff_q),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_kind (result_kind),
		.dst_mac     (dst_mac),
		.addr_ip     (addr_ip),
		.out_tag     (out_tag),
		.last        (last)
	);

endmodule

### sv/arp_front.sv
module arp_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           kind,
	input  logic [31:0]          hop_ip,
	input  logic [7:0]           datagram_tag,
	input  logic [1:0]           frame_class,
	input  logic                 parse_ok,
	input  logic [47:0]          frame_dst_mac,
	input  logic                 arp_is_request,
	input  logic [31:0]          sender_ip,
	input  logic [47:0]          sender_mac,
	input  logic [31:0]          target_ip,
	input  logic [15:0]          elapsed_ms,
	input  logic [47:0]          own_mac_q,
	input  logic [31:0]          own_ip_q,
	output logic                 cmd_valid,
	input  logic                 cmd_take,
	output arp_pkg::cmd_t        cmd
);

	arp_pkg::cmd_t cmd_c;
	arp_pkg::cmd_t fifo_q [2];
	logic [1:0]    cnt_q;
	logic          rd_q;
	logic          wr_q;
	logic          push;

	always_comb begin
		cmd_c         = '0;
		cmd_c.op      = arp_pkg::OP_NONE;
		cmd_c.tag     = datagram_tag;
		cmd_c.elapsed = elapsed_ms;
		unique case (kind)
			arp_pkg::KIND_SEND: begin
				cmd_c.op = arp_pkg::OP_SEND;
				cmd_c.ip = hop_ip;
			end
			arp_pkg::KIND_RECV: begin
				if (frame_class == arp_pkg::CLS_ARP && parse_ok) begin
					cmd_c.op    = arp_pkg::OP_LEARN;
					cmd_c.ip    = sender_ip;
					cmd_c.mac   = sender_mac;
					cmd_c.reply = arp_is_request && target_ip == own_ip_q
						&& frame_dst_mac == arp_pkg::BCAST_MAC;
				end else if (frame_class == arp_pkg::CLS_IPV4 && parse_ok
						&& frame_dst_mac == own_mac_q) begin
					cmd_c.op = arp_pkg::OP_DELIVER;
				end
			end
			arp_pkg::KIND_TICK: cmd_c.op = arp_pkg::OP_TICK;
			default: cmd_c.op = arp_pkg::OP_NONE;
		endcase
	end

	assign in_stall  = (cnt_q == 2'd2);
	assign push      = in_valid && !in_stall && cmd_c.op != arp_pkg::OP_NONE;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = fifo_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (cmd_take) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_take};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= cmd_c;
		end
	end

endmodule

### sv/arp_back.sv
module arp_back #(
	parameter int MAP_ENTRIES  = arp_pkg::MAP_ENTRIES_DEF,
	parameter int ASK_ENTRIES  = arp_pkg::ASK_ENTRIES_DEF,
	parameter int PARK_ENTRIES = arp_pkg::PARK_ENTRIES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_take,
	input  arp_pkg::cmd_t cmd,
	input  logic [15:0]   lifetime_q,
	input  logic [15:0]   holdoff_q,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [1:0]    result_kind,
	output logic [47:0]   dst_mac,
	output logic [31:0]   addr_ip,
	output logic [7:0]    out_tag,
	output logic          last
);

	localparam int MW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
	localparam int AW = (ASK_ENTRIES > 1) ? $clog2(ASK_ENTRIES) : 1;
	localparam int PW = (PARK_ENTRIES > 1) ? $clog2(PARK_ENTRIES) : 1;
	localparam int CW = $clog2(PARK_ENTRIES + 1);
	localparam int SW = (MW > AW ? MW : AW) + 1;
	localparam logic [CW-1:0] PARK_FULL = CW'(PARK_ENTRIES);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_PARK,
		S_EMIT,
		S_REPLY
	} state_t;

	state_t state_q;

	logic [MAP_ENTRIES-1:0] map_valid_q;
	logic [31:0]            map_ip_q  [MAP_ENTRIES];
	logic [47:0]            map_mac_q [MAP_ENTRIES];
	logic [15:0]            map_age_q [MAP_ENTRIES];
	logic [ASK_ENTRIES-1:0] ask_valid_q;
	logic [31:0]            ask_ip_q  [ASK_ENTRIES];
	logic [15:0]            ask_age_q [ASK_ENTRIES];
	logic [CW-1:0]          park_count_q;
	logic [31:0]            park_ip_q  [PARK_ENTRIES];
	logic [7:0]             park_tag_q [PARK_ENTRIES];

	arp_pkg::cmd_t cmd_q;
	logic [SW-1:0] idx_q;
	logic          map_hit_q;
	logic [MW-1:0] map_slot_q;
	logic          map_free_q;
	logic [MW-1:0] map_fs_q;
	logic [MW-1:0] map_old_q;
	logic          ask_hit_q;
	logic [AW-1:0] ask_slot_q;
	logic          ask_free_q;
	logic [AW-1:0] ask_fs_q;
	logic [AW-1:0] ask_old_q;
	logic [CW-1:0] rd_q;
	logic [CW-1:0] wr_q;
	logic          any_q;
	logic [7:0]    tag_q;

	logic          out_free;
	logic          ask_block;
	logic          emit;
	logic [MW-1:0] mi;
	logic [AW-1:0] ai;
	logic [PW-1:0] pr;
	logic [PW-1:0] pw;
	logic [16:0]   msum;
	logic [16:0]   asum;

	assign out_free  = !out_valid || !out_stall;
	assign cmd_take  = (state_q == S_IDLE) && cmd_valid;
	assign mi        = idx_q[MW-1:0];
	assign ai        = idx_q[AW-1:0];
	assign pr        = rd_q[PW-1:0];
	assign pw        = wr_q[PW-1:0];
	assign msum      = {1'b0, map_age_q[mi]} + {1'b0, cmd_q.elapsed};
	assign asum      = {1'b0, ask_age_q[ai]} + {1'b0, cmd_q.elapsed};
	assign ask_block = ask_hit_q && ask_age_q[ask_slot_q] < holdoff_q;
	assign emit      = out_free && (
		state_q == S_SCAN && cmd_q.op == arp_pkg::OP_DELIVER
		|| state_q == S_DECIDE && cmd_q.op == arp_pkg::OP_SEND && (map_hit_q || !ask_block)
		|| state_q == S_EMIT && any_q
		|| state_q == S_REPLY && (any_q || cmd_q.reply));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			map_valid_q  <= '0;
			ask_valid_q  <= '0;
			park_count_q <= '0;
			out_valid    <= 1'b0;
			cmd_q        <= '0;
			idx_q        <= '0;
			map_hit_q    <= 1'b0;
			map_slot_q   <= '0;
			map_free_q   <= 1'b0;
			map_fs_q     <= '0;
			map_old_q    <= '0;
			ask_hit_q    <= 1'b0;
			ask_slot_q   <= '0;
			ask_free_q   <= 1'b0;
			ask_fs_q     <= '0;
			ask_old_q    <= '0;
			rd_q         <= '0;
			wr_q         <= '0;
			any_q        <= 1'b0;
			tag_q        <= '0;
		end else begin
			out_valid <= emit || (out_valid && out_stall);
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						state_q    <= S_SCAN;
						cmd_q      <= cmd;
						idx_q      <= '0;
						map_hit_q  <= 1'b0;
						map_slot_q <= '0;
						map_free_q <= 1'b0;
						map_fs_q   <= '0;
						map_old_q  <= '0;
						ask_hit_q  <= 1'b0;
						ask_slot_q <= '0;
						ask_free_q <= 1'b0;
						ask_fs_q   <= '0;
						ask_old_q  <= '0;
						rd_q       <= '0;
						wr_q       <= '0;
						any_q      <= 1'b0;
					end
				end
				S_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (cmd_q.op == arp_pkg::OP_DELIVER) begin
						if (out_free) begin
							result_kind <= arp_pkg::RES_DELIVER;
							dst_mac     <= '0;
							addr_ip     <= '0;
							out_tag     <= cmd_q.tag;
							last        <= 1'b1;
							state_q     <= S_IDLE;
						end
					end else if (cmd_q.op == arp_pkg::OP_TICK) begin
						if (int'(idx_q) < MAP_ENTRIES && map_valid_q[mi]) begin
							if (msum > {1'b0, lifetime_q}) begin
								map_valid_q[mi] <= 1'b0;
							end else begin
								map_age_q[mi] <= msum[15:0];
							end
						end
						if (int'(idx_q) < ASK_ENTRIES && ask_valid_q[ai]) begin
							ask_age_q[ai] <= asum[16] ? 16'hFFFF : asum[15:0];
						end
						if (int'(idx_q) == MAP_ENTRIES - 1 && MAP_ENTRIES >= ASK_ENTRIES
								|| int'(idx_q) == ASK_ENTRIES - 1
								&& ASK_ENTRIES >= MAP_ENTRIES) begin
							state_q <= S_IDLE;
						end
					end else begin
						if (int'(idx_q) < MAP_ENTRIES) begin
							if (map_valid_q[mi] && map_ip_q[mi] == cmd_q.ip && !map_hit_q) begin
								map_hit_q  <= 1'b1;
								map_slot_q <= mi;
							end
							if (!map_valid_q[mi] && !map_free_q) begin
								map_free_q <= 1'b1;
								map_fs_q   <= mi;
							end
							if (map_age_q[mi] > map_age_q[map_old_q]) begin
								map_old_q <= mi;
							end
						end
						if (int'(idx_q) < ASK_ENTRIES) begin
							if (ask_valid_q[ai] && ask_ip_q[ai] == cmd_q.ip && !ask_hit_q) begin
								ask_hit_q  <= 1'b1;
								ask_slot_q <= ai;
							end
							if (!ask_valid_q[ai] && !ask_free_q) begin
								ask_free_q <= 1'b1;
								ask_fs_q   <= ai;
							end
							if (ask_age_q[ai] > ask_age_q[ask_old_q]) begin
								ask_old_q <= ai;
							end
						end
						if (int'(idx_q) == MAP_ENTRIES - 1 && MAP_ENTRIES >= ASK_ENTRIES
								|| int'(idx_q) == ASK_ENTRIES - 1
								&& ASK_ENTRIES >= MAP_ENTRIES) begin
							state_q <= S_DECIDE;
						end
					end
				end
				S_DECIDE: begin
					if (cmd_q.op == arp_pkg::OP_SEND) begin
						if (map_hit_q) begin
							if (out_free) begin
								result_kind <= arp_pkg::RES_FRAME;
								dst_mac     <= map_mac_q[map_slot_q];
								addr_ip     <= cmd_q.ip;
								out_tag     <= cmd_q.tag;
								last        <= 1'b1;
								state_q     <= S_IDLE;
							end
						end else if (ask_block) begin
							state_q <= S_IDLE;
						end else if (out_free) begin
							result_kind <= arp_pkg::RES_REQUEST;
							dst_mac     <= arp_pkg::BCAST_MAC;
							addr_ip     <= cmd_q.ip;
							out_tag     <= '0;
							last        <= 1'b1;
							if (park_count_q < PARK_FULL) begin
								park_ip_q[park_count_q[PW-1:0]]  <= cmd_q.ip;
								park_tag_q[park_count_q[PW-1:0]] <= cmd_q.tag;
								park_count_q <= park_count_q + 1'b1;
							end
							if (ask_hit_q) begin
								ask_valid_q[ask_slot_q] <= 1'b1;
								ask_ip_q[ask_slot_q]    <= cmd_q.ip;
								ask_age_q[ask_slot_q]   <= '0;
							end else if (ask_free_q) begin
								ask_valid_q[ask_fs_q] <= 1'b1;
								ask_ip_q[ask_fs_q]    <= cmd_q.ip;
								ask_age_q[ask_fs_q]   <= '0;
							end else begin
								ask_valid_q[ask_old_q] <= 1'b1;
								ask_ip_q[ask_old_q]    <= cmd_q.ip;
								ask_age_q[ask_old_q]   <= '0;
							end
							state_q <= S_IDLE;
						end
					end else begin
						if (map_hit_q) begin
							map_valid_q[map_slot_q] <= 1'b1;
							map_ip_q[map_slot_q]    <= cmd_q.ip;
							map_mac_q[map_slot_q]   <= cmd_q.mac;
							map_age_q[map_slot_q]   <= '0;
						end else if (map_free_q) begin
							map_valid_q[map_fs_q] <= 1'b1;
							map_ip_q[map_fs_q]    <= cmd_q.ip;
							map_mac_q[map_fs_q]   <= cmd_q.mac;
							map_age_q[map_fs_q]   <= '0;
						end else begin
							map_valid_q[map_old_q] <= 1'b1;
							map_ip_q[map_old_q]    <= cmd_q.ip;
							map_mac_q[map_old_q]   <= cmd_q.mac;
							map_age_q[map_old_q]   <= '0;
						end
						if (ask_hit_q) begin
							ask_valid_q[ask_slot_q] <= 1'b0;
						end
						state_q <= S_PARK;
					end
				end
				S_PARK: begin
					if (rd_q == park_count_q) begin
						park_count_q <= wr_q;
						state_q      <= S_REPLY;
					end else if (park_ip_q[pr] == cmd_q.ip) begin
						state_q <= S_EMIT;
					end else begin
						park_ip_q[pw]  <= park_ip_q[pr];
						park_tag_q[pw] <= park_tag_q[pr];
						wr_q <= wr_q + 1'b1;
						rd_q <= rd_q + 1'b1;
					end
				end
				S_EMIT: begin
					// hold each release back one step until it is known whether it is the final one
					if (!any_q || out_free) begin
						if (any_q) begin
							result_kind <= arp_pkg::RES_FRAME;
							dst_mac     <= cmd_q.mac;
							addr_ip     <= cmd_q.ip;
							out_tag     <= tag_q;
							last        <= 1'b0;
						end
						any_q   <= 1'b1;
						tag_q   <= park_tag_q[pr];
						rd_q    <= rd_q + 1'b1;
						state_q <= S_PARK;
					end
				end
				S_REPLY: begin
					if (any_q) begin
						if (out_free) begin
							result_kind <= arp_pkg::RES_FRAME;
							dst_mac     <= cmd_q.mac;
							addr_ip     <= cmd_q.ip;
							out_tag     <= tag_q;
							last        <= !cmd_q.reply;
							any_q       <= 1'b0;
							if (!cmd_q.reply) begin
								state_q <= S_IDLE;
							end
						end
					end else if (cmd_q.reply) begin
						if (out_free) begin
							result_kind <= arp_pkg::RES_REPLY;
							dst_mac     <= cmd_q.mac;
							addr_ip     <= cmd_q.ip;
							out_tag     <= '0;
							last        <= 1'b1;
							state_q     <= S_IDLE;
						end
					end else begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### tb/tb_arp_resolution_engine.sv
module tb_arp_resolution_engine;

	typedef struct {
		logic [1:0]  kind;
		logic [31:0] hop;
		logic [7:0]  tag;
		logic [1:0]  cls;
		logic        ok;
		logic [47:0] fdst;
		logic        isreq;
		logic [31:0] sip;
		logic [47:0] smac;
		logic [31:0] tip;
		logic [15:0] elapsed;
	} event_t;

	typedef struct {
		logic [1:0]  rkind;
		logic [47:0] mac;
		logic [31:0] ip;
		logic [7:0]  tag;
		logic        last;
	} frame_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [1:0]  kind = 0;
	logic [31:0] hop_ip = 0;
	logic [7:0]  datagram_tag = 0;
	logic [1:0]  frame_class = 0;
	logic        parse_ok = 0;
	logic [47:0] frame_dst_mac = 0;
	logic        arp_is_request = 0;
	logic [31:0] sender_ip = 0;
	logic [47:0] sender_mac = 0;
	logic [31:0] target_ip = 0;
	logic [15:0] elapsed_ms = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [1:0]  result_kind;
	logic [47:0] dst_mac;
	logic [31:0] addr_ip;
	logic [7:0]  out_tag;
	logic        last;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = 0;
	logic [47:0] cfg_data = 0;

	arp_resolution_engine DUT (.*);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	logic [47:0] my_mac;
	logic [31:0] my_ip;
	logic [15:0] lifetime, holdoff;
	bit          cache_valid [16];
	logic [31:0] cache_ip [16];
	logic [47:0] cache_mac [16];
	logic [15:0] cache_age [16];
	bit          ask_valid [16];
	logic [31:0] ask_ip [16];
	logic [15:0] ask_age [16];
	int          parked;
	logic [31:0] park_ip [16];
	logic [7:0]  park_tag [16];

	event_t pending_events[$];
	frame_t expected_frames[$];
	int     errors = 0, sent = 0, seen = 0;
	bit     quiet = 0, hold_rx = 0;
	bit     in_acc = 0;
	int     hold_cycles = 0;

	function automatic int cache_lookup(logic [31:0] ip);
		for (int i = 0; i < 16; i++)
			if (cache_valid[i] && cache_ip[i] == ip) return i;
		return -1;
	endfunction

	function automatic int ask_lookup(logic [31:0] ip);
		for (int i = 0; i < 16; i++)
			if (ask_valid[i] && ask_ip[i] == ip) return i;
		return -1;
	endfunction

	task automatic add_event(event_t e);
		pending_events.insert(pending_events.size(), e);
	endtask

	task automatic push_frame(logic [1:0] k, logic [47:0] m, logic [31:0] ip, logic [7:0] t);
		frame_t f;
		f.rkind = k; f.mac = m; f.ip = ip; f.tag = t; f.last = 0;
		expected_frames.insert(expected_frames.size(), f);
	endtask

	task automatic resolve_event(event_t e);
		int n0, slot, a, w;
		logic [16:0] sum;
		n0 = expected_frames.size();
		if (e.kind == arp_pkg::KIND_SEND) begin
			slot = cache_lookup(e.hop);
			if (slot >= 0) push_frame(arp_pkg::RES_FRAME, cache_mac[slot], e.hop, e.tag);
			else begin
				a = ask_lookup(e.hop);
				if (a < 0 || ask_age[a] >= holdoff) begin
					push_frame(arp_pkg::RES_REQUEST, arp_pkg::BCAST_MAC, e.hop, 8'h00);
					if (parked < 16) begin
						park_ip[parked] = e.hop;
						park_tag[parked] = e.tag;
						parked++;
					end
					slot = a;
					for (int i = 0; i < 16 && slot < 0; i++) if (!ask_valid[i]) slot = i;
					if (slot < 0) begin
						slot = 0;
						for (int i = 1; i < 16; i++) if (ask_age[i] > ask_age[slot]) slot = i;
					end
					ask_valid[slot] = 1; ask_ip[slot] = e.hop; ask_age[slot] = 0;
				end
			end
		end else if (e.kind == arp_pkg::KIND_RECV) begin
			if (e.cls == arp_pkg::CLS_ARP && e.ok) begin
				a = ask_lookup(e.sip);
				slot = cache_lookup(e.sip);
				for (int i = 0; i < 16 && slot < 0; i++) if (!cache_valid[i]) slot = i;
				if (slot < 0) begin
					slot = 0;
					for (int i = 1; i < 16; i++) if (cache_age[i] > cache_age[slot]) slot = i;
				end
				cache_valid[slot] = 1; cache_ip[slot] = e.sip;
				cache_mac[slot] = e.smac; cache_age[slot] = 0;
				if (a >= 0) ask_valid[a] = 0;
				w = 0;
				for (int k = 0; k < parked; k++) begin
					if (park_ip[k] == e.sip)
						push_frame(arp_pkg::RES_FRAME, e.smac, e.sip, park_tag[k]);
					else begin
						park_ip[w] = park_ip[k]; park_tag[w] = park_tag[k]; w++;
					end
				end
				parked = w;
				if (e.isreq && e.tip == my_ip && e.fdst == arp_pkg::BCAST_MAC)
					push_frame(arp_pkg::RES_REPLY, e.smac, e.sip, 8'h00);
			end else if (e.cls == arp_pkg::CLS_IPV4 && e.fdst == my_mac && e.ok)
				push_frame(arp_pkg::RES_DELIVER, 48'h0, 32'h0, e.tag);
		end else if (e.kind == arp_pkg::KIND_TICK) begin
			for (int i = 0; i < 16; i++) begin
				if (!cache_valid[i]) continue;
				sum = cache_age[i] + e.elapsed;
				if (sum > lifetime) cache_valid[i] = 0;
				else cache_age[i] = sum[15:0];
			end
			for (int i = 0; i < 16; i++) begin
				if (!ask_valid[i]) continue;
				sum = ask_age[i] + e.elapsed;
				ask_age[i] = sum > 17'hFFFF ? 16'hFFFF : sum[15:0];
			end
		end
		if (expected_frames.size() > n0) expected_frames[$].last = 1;
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			if (in_acc) begin
				resolve_event(pending_events.pop_front());
				sent++;
			end
			if (!in_valid || in_acc) begin
				if (pending_events.size() > 0 && (quiet || $urandom_range(99) >= 24)) begin
					in_valid <= 1;
					kind <= pending_events[0].kind;
					hop_ip <= pending_events[0].hop;
					datagram_tag <= pending_events[0].tag;
					frame_class <= pending_events[0].cls;
					parse_ok <= pending_events[0].ok;
					frame_dst_mac <= pending_events[0].fdst;
					arp_is_request <= pending_events[0].isreq;
					sender_ip <= pending_events[0].sip;
					sender_mac <= pending_events[0].smac;
					target_ip <= pending_events[0].tip;
					elapsed_ms <= pending_events[0].elapsed;
				end else
					in_valid <= 0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				out_stall <= 1;
			end else if (hold_rx) begin
				hold_cycles <= 300;
				out_stall <= 1;
			end else
				out_stall <= !quiet && $urandom_range(99) < 24;
		end
	end

	always @(posedge clk) begin
		frame_t f;
		in_acc <= arst_n && in_valid && !in_stall;
		if (arst_n && out_valid && !out_stall) begin
			seen++;
			if (expected_frames.size() == 0) begin
				$display("%0t: unexpected result kind=%0d mac=%h ip=%h tag=%h last=%b",
					$time, result_kind, dst_mac, addr_ip, out_tag, last);
				errors++;
			end else begin
				f = expected_frames.pop_front();
				if (result_kind !== f.rkind || dst_mac !== f.mac || addr_ip !== f.ip ||
					out_tag !== f.tag || last !== f.last) begin
					$display("%0t: mismatch expected kind=%0d mac=%h ip=%h tag=%h last=%b",
						$time, f.rkind, f.mac, f.ip, f.tag, f.last);
					$display("%0t:          actual kind=%0d mac=%h ip=%h tag=%h last=%b",
						$time, result_kind, dst_mac, addr_ip, out_tag, last);
					errors++;
				end
			end
		end
	end

	function automatic event_t blank_event();
		event_t e;
		e.kind = arp_pkg::KIND_TICK; e.hop = 0; e.tag = 0; e.cls = arp_pkg::CLS_ARP; e.ok = 1;
		e.fdst = arp_pkg::BCAST_MAC; e.isreq = 0; e.sip = 0; e.smac = 0; e.tip = 0;
		e.elapsed = 0;
		return e;
	endfunction

	function automatic logic [31:0] pick_ip();
		return $urandom_range(7) == 0 ? $urandom : 32'h0A00_0000 | $urandom_range(23);
	endfunction

	function automatic logic [47:0] rand48();
		return 48'({$urandom, $urandom});
	endfunction

	function automatic event_t random_event();
		event_t e;
		int r;
		e = blank_event();
		r = $urandom_range(99);
		e.tag = 8'($urandom);
		e.hop = pick_ip();
		e.sip = pick_ip();
		e.smac = rand48();
		e.tip = $urandom_range(2) == 0 ? my_ip : pick_ip();
		e.isreq = 1'($urandom);
		e.fdst = $urandom_range(2) == 0 ? rand48()
			: ($urandom_range(1) ? arp_pkg::BCAST_MAC : my_mac);
		e.ok = $urandom_range(9) != 0;
		e.elapsed = 16'($urandom_range(9) == 0 ? $urandom : $urandom_range(3000));
		if (r < 45) e.kind = arp_pkg::KIND_SEND;
		else if (r < 75) begin e.kind = arp_pkg::KIND_RECV; e.cls = arp_pkg::CLS_ARP; end
		else if (r < 85) begin e.kind = arp_pkg::KIND_RECV; e.cls = 2'($urandom); end
		else if (r < 97) e.kind = arp_pkg::KIND_TICK;
		else e.kind = arp_pkg::KIND_RSVD;
		return e;
	endfunction

	task automatic write_reg(logic [1:0] idx, logic [47:0] val);
		@(negedge clk);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 0;
		case (idx)
			arp_pkg::CFG_OWN_MAC:  my_mac = val;
			arp_pkg::CFG_OWN_IP:   my_ip = val[31:0];
			arp_pkg::CFG_LIFETIME: lifetime = val[15:0];
			arp_pkg::CFG_HOLDOFF:  holdoff = val[15:0];
		endcase
	endtask

	task automatic drain();
		while (pending_events.size() > 0 || in_valid || expected_frames.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	initial begin
		event_t e;
		my_mac = 0; my_ip = 0; lifetime = arp_pkg::LIFETIME_RST; holdoff = arp_pkg::HOLDOFF_RST;
		parked = 0;
		foreach (cache_valid[i]) begin cache_valid[i] = 0; ask_valid[i] = 0; end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		write_reg(arp_pkg::CFG_OWN_MAC, 48'h0200_1122_3344);
		write_reg(arp_pkg::CFG_OWN_IP, 48'h0A00_0001);

		// Directed: miss, holdoff drop, tick, learn and release, hit, reply, deliver, park overflow.
		e = blank_event(); e.kind = arp_pkg::KIND_SEND; e.hop = 32'h0A00_0005; e.tag = 8'hFF;
		add_event(e);
		e.tag = 8'h00; add_event(e);
		e = blank_event(); e.kind = arp_pkg::KIND_TICK; e.elapsed = 16'hFFFF;
		add_event(e);
		e = blank_event(); e.kind = arp_pkg::KIND_SEND; e.hop = 32'h0A00_0005; e.tag = 8'h5A;
		add_event(e);
		e = blank_event(); e.kind = arp_pkg::KIND_RECV; e.sip = 32'h0A00_0005;
		e.smac = 48'hFFFF_FFFF_FFFF; e.isreq = 1; e.tip = 32'h0A00_0001;
		add_event(e);
		e = blank_event(); e.kind = arp_pkg::KIND_SEND; e.hop = 32'h0A00_0005; e.tag = 8'hA5;
		add_event(e);
		e = blank_event(); e.kind = arp_pkg::KIND_RECV; e.cls = arp_pkg::CLS_IPV4;
		e.fdst = 48'h0200_1122_3344;
		e.tag = 8'h77; add_event(e);
		e.ok = 0; add_event(e);
		e.ok = 1; e.cls = arp_pkg::CLS_OTHER; add_event(e);
		e.cls = arp_pkg::CLS_RSVD; add_event(e);
		e = blank_event(); e.kind = arp_pkg::KIND_RSVD; add_event(e);
		e = blank_event(); e.kind = arp_pkg::KIND_RECV; e.ok = 0; e.sip = 32'hFFFF_FFFF;
		add_event(e);
		for (int i = 0; i < 18; i++) begin
			e = blank_event(); e.kind = arp_pkg::KIND_SEND; e.hop = 32'hC0A8_0000 + i;
			e.tag = 8'(i);
			add_event(e);
		end
		e = blank_event(); e.kind = arp_pkg::KIND_RECV; e.sip = 32'hC0A8_0001; e.smac = 48'h1;
		add_event(e);
		drain();

		write_reg(arp_pkg::CFG_LIFETIME, 48'd1);
		write_reg(arp_pkg::CFG_HOLDOFF, 48'd0);
		for (int i = 0; i < 60; i++) add_event(random_event());
		drain();

		write_reg(arp_pkg::CFG_LIFETIME, 48'hFFFF);
		write_reg(arp_pkg::CFG_HOLDOFF, 48'hFFFF);
		write_reg(arp_pkg::CFG_OWN_MAC, 48'hFFFF_FFFF_FFFF);
		write_reg(arp_pkg::CFG_OWN_IP, 48'hFFFF_FFFF);
		for (int i = 0; i < 60; i++) add_event(random_event());
		hold_rx = 1;
		repeat (20) @(posedge clk);
		hold_rx = 0;
		drain();

		write_reg(arp_pkg::CFG_OWN_MAC, 48'h0);
		write_reg(arp_pkg::CFG_OWN_IP, 48'h0A00_0001);
		write_reg(arp_pkg::CFG_LIFETIME, 48'd8000);
		write_reg(arp_pkg::CFG_HOLDOFF, 48'd2000);
		quiet = 1;
		for (int i = 0; i < 100; i++) add_event(random_event());
		drain();
		quiet = 0;
		for (int i = 0; i < 250; i++) add_event(random_event());
		drain();

		$display("Covered %0d events and %0d results over four register settings.", sent, seen);
		if (errors == 0)
			$display("arp_resolution_engine test passed");
		else
			$display("arp_resolution_engine test failed");
		$finish;
	end

	initial begin
		#4000000;
		$display("arp_resolution_engine test failed");
		$finish;
	end
endmodule
